>>> design/assert_macros.svh
// Assertion macros used by the controller of the LED cube scan driver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CHECK(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CHECK(name, clk, rst, prop)
`define ASSERT_NEVER(name, clk, rst, expr)
`endif
`endif

>>> design/lcbsd_pkg.sv
// Shared constants, codes and interface types of the LED cube scan driver.
`default_nettype none
package lcbsd_pkg;

   localparam int CUBE_SIDE    = 8;
   localparam int LED_COUNT    = 512;
   localparam int CHANNEL_BITS = 8;

   localparam int ADDR_W   = $clog2(LED_COUNT);
   localparam int PTR_W    = ADDR_W + 1;
   localparam int COLOR_W  = 24;
   localparam int LAYER_W  = $clog2(CUBE_SIDE);
   localparam int WEIGHT_W = $clog2(CHANNEL_BITS);
   localparam int UNIT_W   = 16;
   localparam int DWELL_W  = 24;
   localparam int PHASE_W  = 6;
   localparam int ROW_SHIFT = $clog2(CUBE_SIDE * CUBE_SIDE);

   localparam int SHIFT_PHASES = 6 * CUBE_SIDE;
   localparam logic [PHASE_W-1:0] PH_START      = PHASE_W'(0);
   localparam logic [PHASE_W-1:0] PH_SHIFT_LAST = PHASE_W'(SHIFT_PHASES);
   localparam logic [PHASE_W-1:0] PH_LATCH      = PHASE_W'(SHIFT_PHASES + 1);
   localparam logic [PHASE_W-1:0] PH_DWELL      = PHASE_W'(SHIFT_PHASES + 2);
   localparam logic [PHASE_W-1:0] PH_OFF        = PHASE_W'(SHIFT_PHASES + 3);

   localparam logic [CUBE_SIDE-1:0] LAYER_MASK = {CUBE_SIDE{1'b1}};
   localparam int RSP_W = 3 + CUBE_SIDE;
   localparam int RSP_TDATA_W = ((RSP_W + 7) / 8) * 8;
   localparam int REQ_FIELDS_W = ADDR_W + COLOR_W;
   localparam int REQ_TDATA_W = ((REQ_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_SWAP  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_TICK  = 2'd3
   } kind_type;

   typedef struct packed {
      logic write_pixel;
      logic swap;
      logic clear_start;
      logic clear_step;
      logic clear_all;
      logic tick;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic need_read;
      logic clear_last;
   } status_type;

endpackage
`default_nettype wire

>>> design/lcbsd_datapath.sv
// Frame banks, scan sequencer registers, pin levels and result register.
`default_nettype none
module lcbsd_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire lcbsd_pkg::cmd_type                  cmd,
   output lcbsd_pkg::status_type                    status,
   input  wire logic [lcbsd_pkg::ADDR_W-1:0]        pixel_index,
   input  wire logic [lcbsd_pkg::COLOR_W-1:0]       color,
   input  wire logic                                csr_wr_en,
   input  wire logic [lcbsd_pkg::UNIT_W-1:0]        csr_wr_data,
   output logic [lcbsd_pkg::RSP_TDATA_W-1:0]        rsp_data
);

   logic [lcbsd_pkg::COLOR_W-1:0] bank0_mem [lcbsd_pkg::LED_COUNT];
   logic [lcbsd_pkg::COLOR_W-1:0] bank1_mem [lcbsd_pkg::LED_COUNT];
   logic [lcbsd_pkg::COLOR_W-1:0] rd0_ff, rd1_ff;

   logic                           front_ff, front_in;
   logic                           slot_front_ff, slot_front_in;
   logic [lcbsd_pkg::LAYER_W-1:0]  layer_ff, layer_in;
   logic [lcbsd_pkg::WEIGHT_W-1:0] weight_ff, weight_in;
   logic [lcbsd_pkg::PHASE_W-1:0]  phase_ff, phase_in;
   logic [lcbsd_pkg::DWELL_W-1:0]  dwell_ff, dwell_in;
   logic [lcbsd_pkg::PTR_W-1:0]    ptr_ff, ptr_in;
   logic [lcbsd_pkg::UNIT_W-1:0]   unit_ff, unit_in;
   logic                           data_ff, data_in;
   logic                           sclk_ff, sclk_in;
   logic                           latch_ff, latch_in;
   logic [lcbsd_pkg::CUBE_SIDE-1:0] layers_n_ff, layers_n_in;
   logic [lcbsd_pkg::RSP_TDATA_W-1:0] rsp_ff, rsp_in;

   logic [lcbsd_pkg::PHASE_W-1:0]  shift_idx;
   logic [1:0]                     chan;
   logic [lcbsd_pkg::LAYER_W-1:0]  pos_x;
   logic [lcbsd_pkg::ADDR_W-1:0]   rd_addr;
   logic [lcbsd_pkg::ADDR_W-1:0]   wr_addr;
   logic [lcbsd_pkg::COLOR_W-1:0]  wr_data;
   logic                           we0, we1, pix_ok;
   logic [lcbsd_pkg::COLOR_W-1:0]  shown_word;
   logic [7:0]                     chan_byte;
   logic                           shift_bit;
   logic [lcbsd_pkg::CUBE_SIDE-1:0] layer_bit;

   // Bit k of the shift sequence sits at phase 2k+1; k picks channel and column.
   assign shift_idx = (phase_ff - lcbsd_pkg::PHASE_W'(1)) >> 1;
   assign chan      = 2'(shift_idx / lcbsd_pkg::CUBE_SIDE);
   assign pos_x     = lcbsd_pkg::LAYER_W'(shift_idx % lcbsd_pkg::CUBE_SIDE);
   assign rd_addr   = lcbsd_pkg::ADDR_W'(pos_x)
                    + (lcbsd_pkg::ADDR_W'(layer_ff) << lcbsd_pkg::ROW_SHIFT);

   assign status.need_read  = phase_ff[0] && (phase_ff <= lcbsd_pkg::PH_SHIFT_LAST);
   assign status.clear_last = ptr_ff == lcbsd_pkg::PTR_W'(lcbsd_pkg::LED_COUNT - 1);

   assign pix_ok  = {1'b0, pixel_index} < lcbsd_pkg::PTR_W'(lcbsd_pkg::LED_COUNT);
   assign wr_addr = cmd.clear_step ? ptr_ff[lcbsd_pkg::ADDR_W-1:0] : pixel_index;
   assign wr_data = cmd.clear_step ? '0 : color;
   // The back bank is the one not at the front; the reset sweep clears both.
   assign we0 = (cmd.write_pixel && pix_ok && front_ff)
             || (cmd.clear_step && (cmd.clear_all || front_ff));
   assign we1 = (cmd.write_pixel && pix_ok && !front_ff)
             || (cmd.clear_step && (cmd.clear_all || !front_ff));

   always_ff @(posedge clock) begin
      if (we0) begin
         bank0_mem[wr_addr] <= wr_data;
      end
      rd0_ff <= bank0_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (we1) begin
         bank1_mem[wr_addr] <= wr_data;
      end
      rd1_ff <= bank1_mem[rd_addr];
   end

   assign shown_word = slot_front_ff ? rd1_ff : rd0_ff;

   always_comb begin
      unique case (chan)
         2'd0:    chan_byte = shown_word[23:16];
         2'd1:    chan_byte = shown_word[15:8];
         default: chan_byte = shown_word[7:0];
      endcase
   end

   assign shift_bit = chan_byte[weight_ff];
   assign layer_bit = lcbsd_pkg::CUBE_SIDE'(1) << layer_ff;

   always_comb begin
      front_in      = front_ff;
      slot_front_in = slot_front_ff;
      layer_in      = layer_ff;
      weight_in     = weight_ff;
      phase_in      = phase_ff;
      dwell_in      = dwell_ff;
      ptr_in        = ptr_ff;
      unit_in       = csr_wr_en ? csr_wr_data : unit_ff;
      data_in       = data_ff;
      sclk_in       = sclk_ff;
      latch_in      = latch_ff;
      layers_n_in   = layers_n_ff;

      if (cmd.swap) begin
         front_in = !front_ff;
      end
      if (cmd.clear_start) begin
         ptr_in = '0;
      end else if (cmd.clear_step) begin
         ptr_in = ptr_ff + lcbsd_pkg::PTR_W'(1);
      end

      if (cmd.tick) begin
         priority if (phase_ff == lcbsd_pkg::PH_START) begin
            slot_front_in = front_ff;
            layers_n_in   = layers_n_ff & ~layer_bit;
            latch_in      = 1'b0;
            phase_in      = lcbsd_pkg::PHASE_W'(1);
         end else if (phase_ff <= lcbsd_pkg::PH_SHIFT_LAST) begin
            if (phase_ff[0]) begin
               sclk_in = 1'b0;
               data_in = shift_bit;
            end else begin
               sclk_in = 1'b1;
            end
            phase_in = phase_ff + lcbsd_pkg::PHASE_W'(1);
         end else if (phase_ff == lcbsd_pkg::PH_LATCH) begin
            latch_in = 1'b1;
            dwell_in = lcbsd_pkg::DWELL_W'(unit_ff) << weight_ff;
            phase_in = lcbsd_pkg::PH_DWELL;
         end else if (phase_ff == lcbsd_pkg::PH_DWELL) begin
            if (dwell_ff > lcbsd_pkg::DWELL_W'(1)) begin
               dwell_in = dwell_ff - lcbsd_pkg::DWELL_W'(1);
            end else begin
               dwell_in = '0;
               phase_in = lcbsd_pkg::PH_OFF;
            end
         end else begin
            layers_n_in = layers_n_ff | layer_bit;
            if (layer_ff == lcbsd_pkg::LAYER_W'(lcbsd_pkg::CUBE_SIDE - 1)) begin
               layer_in = '0;
               if (weight_ff == '0) begin
                  weight_in = lcbsd_pkg::WEIGHT_W'(lcbsd_pkg::CHANNEL_BITS - 1);
               end else begin
                  weight_in = weight_ff - lcbsd_pkg::WEIGHT_W'(1);
               end
            end else begin
               layer_in = layer_ff + lcbsd_pkg::LAYER_W'(1);
            end
            phase_in = lcbsd_pkg::PH_START;
         end
      end

      rsp_in = rsp_ff;
      if (cmd.load_rsp) begin
         rsp_in = lcbsd_pkg::RSP_TDATA_W'({layers_n_in, latch_in, sclk_in, data_in});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff      <= 1'b0;
         slot_front_ff <= 1'b0;
         layer_ff      <= '0;
         weight_ff     <= lcbsd_pkg::WEIGHT_W'(lcbsd_pkg::CHANNEL_BITS - 1);
         phase_ff      <= lcbsd_pkg::PH_START;
         dwell_ff      <= '0;
         ptr_ff        <= '0;
         unit_ff       <= lcbsd_pkg::UNIT_W'(1);
         data_ff       <= 1'b0;
         sclk_ff       <= 1'b0;
         latch_ff      <= 1'b0;
         layers_n_ff   <= lcbsd_pkg::LAYER_MASK;
      end else begin
         front_ff      <= front_in;
         slot_front_ff <= slot_front_in;
         layer_ff      <= layer_in;
         weight_ff     <= weight_in;
         phase_ff      <= phase_in;
         dwell_ff      <= dwell_in;
         ptr_ff        <= ptr_in;
         unit_ff       <= unit_in;
         data_ff       <= data_in;
         sclk_ff       <= sclk_in;
         latch_ff      <= latch_in;
         layers_n_ff   <= layers_n_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

>>> design/lcbsd_ctrl.sv
// Controller: input handshake, bank clearing sweeps, read wait and result valid.
`default_nettype none
`include "assert_macros.svh"
module lcbsd_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [1:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output lcbsd_pkg::cmd_type         cmd,
   input  wire lcbsd_pkg::status_type status
);

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_TICK_READ,
      ST_CLEAR
   } state_type;

   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;
   lcbsd_pkg::kind_type kind;

   assign kind       = lcbsd_pkg::kind_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_INIT: begin
            cmd.clear_step = 1'b1;
            cmd.clear_all  = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (kind)
                  lcbsd_pkg::KIND_WRITE: begin
                     cmd.write_pixel = 1'b1;
                     cmd.load_rsp    = 1'b1;
                  end
                  lcbsd_pkg::KIND_SWAP: begin
                     cmd.swap     = 1'b1;
                     cmd.load_rsp = 1'b1;
                  end
                  lcbsd_pkg::KIND_CLEAR: begin
                     cmd.clear_start = 1'b1;
                     state_in        = ST_CLEAR;
                  end
                  lcbsd_pkg::KIND_TICK: begin
                     // A data bit waits in ST_TICK_READ for the registered frame bank read.
                     if (status.need_read) begin
                        state_in = ST_TICK_READ;
                     end else begin
                        cmd.tick     = 1'b1;
                        cmd.load_rsp = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_TICK_READ: begin
            cmd.tick     = 1'b1;
            cmd.load_rsp = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `ASSERT_CHECK(a_busy_blocks_input, clock, reset, (state_ff != ST_IDLE) |-> !req_tready)
   `ASSERT_CHECK(a_read_wait_one_cycle, clock, reset, (state_ff == ST_TICK_READ) |=> (state_ff == ST_IDLE && rsp_valid_ff))
   `ASSERT_CHECK(a_clear_ends_with_word, clock, reset, (state_ff == ST_CLEAR && status.clear_last) |=> (state_ff == ST_IDLE && rsp_valid_ff))
   `ASSERT_NEVER(a_no_write_during_sweep, clock, reset, cmd.write_pixel && cmd.clear_step)

endmodule
`default_nettype wire

>>> design/led_cube_bam_scan_driver_unit.sv
// Top level of the LED cube bit-angle-modulation scan driver.
//
//   Channel   Direction  Handshake                 Content
//   req_      in         req_tvalid / req_tready   tuser kind, tdata pixel and color
//   rsp_      out        rsp_tvalid / rsp_tready   tdata pin levels after each word
//   csr_      in         csr_wr_en                 dwell_unit register
//
// Pixel writes, swaps and ticks without a data bit load the result register as
// the word is accepted; a tick that shifts out a data bit first waits in the
// read state, since the frame bank read is registered. A bank clear sweeps the
// back bank one entry per cycle. After reset both banks are cleared in one pass;
// no word is accepted until it ends. The next word is accepted as soon as the
// result register is free or is being taken in the same cycle.
`default_nettype none
module led_cube_bam_scan_driver_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: pixel_index [8:0], color [32:9], zero fill [39:33]
   input  wire logic [lcbsd_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: kind [1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: serial_data [0], shift_clock [1], latch [2], layer_enable_n [10:3],
   // zero fill [15:11]
   output logic [lcbsd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic        csr_wr_en,
   input  wire logic [lcbsd_pkg::UNIT_W-1:0] csr_wr_data
);

   lcbsd_pkg::cmd_type    cmd;
   lcbsd_pkg::status_type status;

   lcbsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   lcbsd_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .pixel_index (req_tdata[lcbsd_pkg::ADDR_W-1:0]),
      .color       (req_tdata[lcbsd_pkg::REQ_FIELDS_W-1:lcbsd_pkg::ADDR_W]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_data    (rsp_tdata)
   );

endmodule
`default_nettype wire
